FILE: hw/rtl/coordinate_selection_set_defines.svh
// assertion macros for the coordinate selection set
`ifndef COORDINATE_SELECTION_SET_DEFINES_SVH
`define COORDINATE_SELECTION_SET_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication under reset
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("css assertion failed");
// next-cycle implication under reset
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("css assertion failed");
`else
`define CSS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CSS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: hw/rtl/css_pkg.sv
// types and codes shared by the coordinate selection set
`default_nettype none
package css_pkg;

    localparam logic [2:0] CMD_ADD     = 3'd0;
    localparam logic [2:0] CMD_REMOVE  = 3'd1;
    localparam logic [2:0] CMD_TOGGLE  = 3'd2;
    localparam logic [2:0] CMD_CLR_STK = 3'd3;
    localparam logic [2:0] CMD_CLR_SEL = 3'd4;
    localparam logic [2:0] CMD_READ    = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SEL_FULL = 2'd1;
    localparam logic [1:0] ST_STK_FULL = 2'd2;
    localparam logic [1:0] ST_RANGE    = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [7:0]         read_index;
    } t_in;

    typedef struct packed {
        logic               was_member;
        logic               now_member;
        logic [8:0]         entry_count;
        logic [1:0]         status;
        logic signed [15:0] entry_x;
        logic signed [15:0] entry_y;
    } t_out;

endpackage
`default_nettype wire

FILE: hw/rtl/css_ram.sv
// simple dual-port ram with registered read data
`default_nettype none
module css_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/css_ctrl.sv
// sequencer that scans, shifts and appends the selection and stroke memories
`default_nettype none
`include "coordinate_selection_set_defines.svh"
module css_ctrl #(
    parameter int SELECTION_DEPTH = 256,
    parameter int STROKE_DEPTH    = 256,
    parameter int COORD_BITS      = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_in_valid,
    output logic              o_in_ready,
    input  wire css_pkg::t_in i_in_item,
    output logic              o_res_valid,
    input  wire logic         i_res_ready,
    output css_pkg::t_out     o_res
);

    localparam int AW_S = $clog2(SELECTION_DEPTH);
    localparam int CW_S = $clog2(SELECTION_DEPTH + 1);
    localparam int AW_K = $clog2(STROKE_DEPTH);
    localparam int CW_K = $clog2(STROKE_DEPTH + 1);
    localparam int KW   = 2 * COORD_BITS;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SSCAN  = 3'd1;
    localparam logic [2:0] S_KSCAN  = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_SHIFT  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0]        r_state, n_state;
    logic [2:0]        r_cmd, n_cmd;
    logic [KW-1:0]     r_key, n_key;
    logic [7:0]        r_idx_in, n_idx_in;
    logic [CW_S-1:0]   r_sel_cnt, n_sel_cnt;
    logic [CW_K-1:0]   r_stk_cnt, n_stk_cnt;
    logic [CW_S-1:0]   r_ptr, n_ptr;
    logic [CW_K-1:0]   r_kptr, n_kptr;
    logic              r_pend, n_pend;
    logic [AW_S-1:0]   r_didx, n_didx;
    logic              r_was, n_was;
    logic [AW_S-1:0]   r_at, n_at;
    logic              r_instk, n_instk;
    logic              r_now, n_now;
    logic [1:0]        r_status, n_status;
    logic [15:0]       r_ex, n_ex;
    logic [15:0]       r_ey, n_ey;

    logic              sel_we, sel_re, stk_we, stk_re;
    logic [AW_S-1:0]   sel_waddr, sel_raddr;
    logic [AW_K-1:0]   stk_waddr, stk_raddr;
    logic [KW-1:0]     sel_wdata, sel_rdata, stk_rdata;

    // coordinate width conversion
    logic [COORD_BITS+15:0] w_xin, w_yin, w_xout, w_yout;
    logic [COORD_BITS-1:0]  w_rx, w_ry;
    logic [CW_S+7:0]        w_idx_ext, w_cnt_ext;
    logic [AW_S+7:0]        w_idx_addr;
    logic [CW_S+8:0]        w_cnt9;
    logic                   w_sel_full, w_stk_full, w_sel_hit, w_stk_hit;

    assign w_xin      = {{COORD_BITS{i_in_item.pos_x[15]}}, i_in_item.pos_x};
    assign w_yin      = {{COORD_BITS{i_in_item.pos_y[15]}}, i_in_item.pos_y};
    assign w_rx       = sel_rdata[KW-1:COORD_BITS];
    assign w_ry       = sel_rdata[COORD_BITS-1:0];
    assign w_xout     = {{16{w_rx[COORD_BITS-1]}}, w_rx};
    assign w_yout     = {{16{w_ry[COORD_BITS-1]}}, w_ry};
    assign w_idx_ext  = {{CW_S{1'b0}}, r_idx_in};
    assign w_cnt_ext  = {8'b0, r_sel_cnt};
    assign w_idx_addr = {{AW_S{1'b0}}, r_idx_in};
    assign w_cnt9     = {9'b0, r_sel_cnt};
    assign w_sel_full = (r_sel_cnt == CW_S'(SELECTION_DEPTH));
    assign w_stk_full = (r_stk_cnt == CW_K'(STROKE_DEPTH));
    assign w_sel_hit  = r_pend && (sel_rdata == r_key);
    assign w_stk_hit  = r_pend && (stk_rdata == r_key);
    assign sel_wdata  = (r_state == S_SHIFT) ? sel_rdata : r_key;

    css_ram #(.DEPTH(SELECTION_DEPTH), .WIDTH(KW)) u_sel_ram (
        .i_clk   (i_clk),
        .i_we    (sel_we),
        .i_waddr (sel_waddr),
        .i_wdata (sel_wdata),
        .i_re    (sel_re),
        .i_raddr (sel_raddr),
        .o_rdata (sel_rdata)
    );

    css_ram #(.DEPTH(STROKE_DEPTH), .WIDTH(KW)) u_stk_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (r_key),
        .i_re    (stk_re),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    always_comb begin
        n_state   = r_state;
        n_cmd     = r_cmd;
        n_key     = r_key;
        n_idx_in  = r_idx_in;
        n_sel_cnt = r_sel_cnt;
        n_stk_cnt = r_stk_cnt;
        n_ptr     = r_ptr;
        n_kptr    = r_kptr;
        n_pend    = r_pend;
        n_didx    = r_didx;
        n_was     = r_was;
        n_at      = r_at;
        n_instk   = r_instk;
        n_now     = r_now;
        n_status  = r_status;
        n_ex      = r_ex;
        n_ey      = r_ey;
        sel_we    = 1'b0;
        sel_waddr = r_sel_cnt[AW_S-1:0];
        sel_re    = 1'b0;
        sel_raddr = r_ptr[AW_S-1:0];
        stk_we    = 1'b0;
        stk_waddr = r_stk_cnt[AW_K-1:0];
        stk_re    = 1'b0;
        stk_raddr = r_kptr[AW_K-1:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd    = i_in_item.command;
                    n_key    = {w_xin[COORD_BITS-1:0], w_yin[COORD_BITS-1:0]};
                    n_idx_in = i_in_item.read_index;
                    n_ptr    = '0;
                    n_pend   = 1'b0;
                    n_was    = 1'b0;
                    n_instk  = 1'b0;
                    n_state  = S_SSCAN;
                end
            end
            S_SSCAN: begin
                // one entry read per cycle, compared the cycle after
                if (w_sel_hit) begin
                    n_was   = 1'b1;
                    n_at    = r_didx;
                    n_pend  = 1'b0;
                    n_kptr  = '0;
                    n_state = (r_cmd == css_pkg::CMD_TOGGLE) ? S_KSCAN : S_DECIDE;
                end else if (r_ptr < r_sel_cnt) begin
                    sel_re = 1'b1;
                    n_didx = r_ptr[AW_S-1:0];
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CW_S'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_kptr  = '0;
                    n_state = (r_cmd == css_pkg::CMD_TOGGLE) ? S_KSCAN : S_DECIDE;
                end
            end
            S_KSCAN: begin
                if (w_stk_hit) begin
                    n_instk = 1'b1;
                    n_pend  = 1'b0;
                    n_state = S_DECIDE;
                end else if (r_kptr < r_stk_cnt) begin
                    stk_re = 1'b1;
                    n_pend = 1'b1;
                    n_kptr = r_kptr + CW_K'(1);
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_now    = r_was;
                n_status = css_pkg::ST_OK;
                n_ex     = '0;
                n_ey     = '0;
                n_state  = S_DONE;
                unique case (r_cmd)
                    css_pkg::CMD_ADD: begin
                        if (!r_was) begin
                            if (w_sel_full) begin
                                n_status = css_pkg::ST_SEL_FULL;
                            end else begin
                                sel_we    = 1'b1;
                                n_sel_cnt = r_sel_cnt + CW_S'(1);
                                n_now     = 1'b1;
                            end
                        end
                    end
                    css_pkg::CMD_REMOVE: begin
                        if (r_was) begin
                            n_now   = 1'b0;
                            n_ptr   = CW_S'(r_at) + CW_S'(1);
                            n_pend  = 1'b0;
                            n_state = S_SHIFT;
                        end
                    end
                    css_pkg::CMD_TOGGLE: begin
                        if (!r_instk) begin
                            if (w_stk_full) begin
                                n_status = css_pkg::ST_STK_FULL;
                            end else begin
                                stk_we    = 1'b1;
                                n_stk_cnt = r_stk_cnt + CW_K'(1);
                                if (r_was) begin
                                    n_now   = 1'b0;
                                    n_ptr   = CW_S'(r_at) + CW_S'(1);
                                    n_pend  = 1'b0;
                                    n_state = S_SHIFT;
                                end else if (w_sel_full) begin
                                    n_status = css_pkg::ST_SEL_FULL;
                                end else begin
                                    sel_we    = 1'b1;
                                    n_sel_cnt = r_sel_cnt + CW_S'(1);
                                    n_now     = 1'b1;
                                end
                            end
                        end
                    end
                    css_pkg::CMD_CLR_STK: begin
                        n_stk_cnt = '0;
                    end
                    css_pkg::CMD_CLR_SEL: begin
                        n_sel_cnt = '0;
                        n_now     = 1'b0;
                    end
                    css_pkg::CMD_READ: begin
                        if (w_idx_ext < w_cnt_ext) begin
                            sel_re    = 1'b1;
                            sel_raddr = w_idx_addr[AW_S-1:0];
                            n_state   = S_RDWAIT;
                        end else begin
                            n_status = css_pkg::ST_RANGE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHIFT: begin
                // move entry j down to j-1 while the next one is read
                if (r_pend) begin
                    sel_we    = 1'b1;
                    sel_waddr = r_didx - AW_S'(1);
                end
                if (r_ptr < r_sel_cnt) begin
                    sel_re = 1'b1;
                    n_didx = r_ptr[AW_S-1:0];
                    n_pend = 1'b1;
                    n_ptr  = r_ptr + CW_S'(1);
                end else begin
                    n_pend    = 1'b0;
                    n_sel_cnt = r_sel_cnt - CW_S'(1);
                    n_state   = S_DONE;
                end
            end
            S_RDWAIT: begin
                n_ex    = w_xout[15:0];
                n_ey    = w_yout[15:0];
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel_cnt <= '0;
            r_stk_cnt <= '0;
            r_pend    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel_cnt <= n_sel_cnt;
            r_stk_cnt <= n_stk_cnt;
            r_pend    <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_key    <= n_key;
        r_idx_in <= n_idx_in;
        r_ptr    <= n_ptr;
        r_kptr   <= n_kptr;
        r_didx   <= n_didx;
        r_was    <= n_was;
        r_at     <= n_at;
        r_instk  <= n_instk;
        r_now    <= n_now;
        r_status <= n_status;
        r_ex     <= n_ex;
        r_ey     <= n_ey;
    end

    assign o_in_ready              = (r_state == S_IDLE);
    assign o_res_valid             = (r_state == S_DONE);
    assign o_res.was_member        = r_was;
    assign o_res.now_member        = r_now;
    assign o_res.entry_count       = w_cnt9[8:0];
    assign o_res.status            = r_status;
    assign o_res.entry_x           = r_ex;
    assign o_res.entry_y           = r_ey;

    `CSS_ASSERT_IMP(a_sel_cnt_max, i_clk, i_rst_n, 1'b1, r_sel_cnt <= CW_S'(SELECTION_DEPTH))
    `CSS_ASSERT_IMP(a_stk_cnt_max, i_clk, i_rst_n, 1'b1, r_stk_cnt <= CW_K'(STROKE_DEPTH))
    `CSS_ASSERT_IMP(a_shift_nonempty, i_clk, i_rst_n, r_state == S_SHIFT, r_sel_cnt != '0)
    `CSS_ASSERT_NXT(a_shift_dec, i_clk, i_rst_n, r_state == S_SHIFT && !(r_ptr < r_sel_cnt), r_sel_cnt == $past(r_sel_cnt) - CW_S'(1))
    `CSS_ASSERT_IMP(a_range_zero, i_clk, i_rst_n, o_res_valid && o_res.status == css_pkg::ST_RANGE, o_res.entry_x == 16'sd0 && o_res.entry_y == 16'sd0)

endmodule
`default_nettype wire

FILE: hw/rtl/coordinate_selection_set.sv
// top level of the coordinate selection set: sequencer plus output register
// one item at a time; one memory read per cycle while scanning the selection and
// stroke memories, one entry moved per cycle while a removal closes the gap
// a result waits in the output register while the next item is already being worked
// reset clears both counts at once; the memories are not cleared and need no pass
`default_nettype none
module coordinate_selection_set #(
    parameter int SELECTION_DEPTH = 256,
    parameter int STROKE_DEPTH    = 256,
    parameter int COORD_BITS      = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire css_pkg::t_in  i_in_item,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output css_pkg::t_out      o_out_item
);

    // handoff between sequencer and output register
    logic          res_valid;
    logic          res_ready;
    css_pkg::t_out res;

    logic          r_out_vld;
    css_pkg::t_out r_out;

    css_ctrl #(
        .SELECTION_DEPTH (SELECTION_DEPTH),
        .STROKE_DEPTH    (STROKE_DEPTH),
        .COORD_BITS      (COORD_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // output register takes a new item when empty or being drained
    assign res_ready = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    // payload register, no reset needed
    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire
